[sv/assert_macros.svh]
// Assertion macros shared by the convex hull RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a condition holds whenever reset is released
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("assertion failed");
// assert that an antecedent implies a consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[sv/chgs_pkg.sv]
// Package: types and constants of the convex hull block
package chgs_pkg;
  localparam int unsigned MaxPoints = 32;
  localparam int unsigned CoordBits = 21;
  localparam int unsigned PosBits = 5;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_PIV,
    ST_SORT_INIT,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_REV_FIND,
    ST_REV_SWAP,
    ST_SCAN_INIT,
    ST_SCAN_CMP,
    ST_LIST,
    ST_HULL_INIT,
    ST_HULL_DUP,
    ST_HULL_OUT,
    ST_DONE
  } state_e;

  // selector for the shared cross-product unit
  typedef enum logic [1:0] {
    OP_TURN,
    OP_DIST
  } op_e;
endpackage

[sv/chgs_point_if.sv]
// Interfaces: input point channel and result channel
interface chgs_point_if #(parameter int unsigned CoordBits = chgs_pkg::CoordBits);
  logic valid;
  logic ready;
  logic signed [CoordBits-1:0] point_x;
  logic signed [CoordBits-1:0] point_y;
  logic final_point;
  modport source (output valid, point_x, point_y, final_point, input ready);
  modport sink (input valid, point_x, point_y, final_point, output ready);
endinterface

interface chgs_result_if #(parameter int unsigned CoordBits = chgs_pkg::CoordBits);
  logic valid;
  logic ready;
  logic item_kind;
  logic [chgs_pkg::PosBits-1:0] sorted_position;
  logic signed [CoordBits-1:0] out_x;
  logic signed [CoordBits-1:0] out_y;
  logic last_result;
  modport source (output valid, item_kind, sorted_position, out_x, out_y, last_result,
                  input ready);
  modport sink (input valid, item_kind, sorted_position, out_x, out_y, last_result,
                output ready);
endinterface

[sv/chgs_cross.sv]
// Shared arithmetic unit: two products per beat, registered, then a signed difference/sum
module chgs_cross #(
  parameter int unsigned CoordBits = chgs_pkg::CoordBits
) (
  input  logic                            clk_i,
  input  chgs_pkg::op_e                   op_i,
  input  logic signed [CoordBits:0]       a0_i,
  input  logic signed [CoordBits:0]       b0_i,
  input  logic signed [CoordBits:0]       a1_i,
  input  logic signed [CoordBits:0]       b1_i,
  output logic signed [2*CoordBits+3:0]   res_o
);
  logic signed [2*CoordBits+1:0] p0_q, p1_q;
  chgs_pkg::op_e op_q;

  always_ff @(posedge clk_i) begin
    p0_q <= a0_i * b0_i;
    p1_q <= a1_i * b1_i;
    op_q <= op_i;
  end

  // turn: a0*b0 - a1*b1 ; distance: a0*b0 + a1*b1
  always_comb begin
    if (op_q == chgs_pkg::OP_DIST) begin
      res_o = {{2{p0_q[2*CoordBits+1]}}, p0_q} + {{2{p1_q[2*CoordBits+1]}}, p1_q};
    end else begin
      res_o = {{2{p0_q[2*CoordBits+1]}}, p0_q} - {{2{p1_q[2*CoordBits+1]}}, p1_q};
    end
  end
endmodule

[sv/convex_hull_graham_scan.sv]
// Top level: convex hull by Graham scan with collinear points kept
// Points are taken one beat per cycle into a store of MaxPoints entries; the beat
// with final_point set closes the set. The block then drops ready and runs a
// sequencer around one shared two-multiplier unit: pivot search (one point per
// cycle), insertion sort clockwise around the pivot (O(n^2) compares), reversal
// of the trailing collinear group, the stack scan with its turn tests, then the
// listing of n sorted points and the hull vertices (each hull vertex needs a
// duplicate search over up to n sorted positions). Results leave through an
// output register and wait for the sink.
module convex_hull_graham_scan #(
  parameter int unsigned MaxPoints = chgs_pkg::MaxPoints,
  parameter int unsigned CoordBits = chgs_pkg::CoordBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  chgs_point_if.sink    in_i,
  chgs_result_if.source out_o
);
  localparam int unsigned IdxBits = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CntBits = $clog2(MaxPoints + 1);
  localparam int unsigned PosBits = chgs_pkg::PosBits;
  localparam int unsigned ResBits = 2 * CoordBits + 4;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [CoordBits:0]   diff_t;
  typedef logic signed [ResBits-1:0]   res_t;

  // point store, sorted order and hull stack
  coord_t            sx_q [MaxPoints];
  coord_t            sy_q [MaxPoints];
  logic [IdxBits-1:0] ord_q [MaxPoints];
  logic [IdxBits-1:0] stk_q [MaxPoints];

  chgs_pkg::state_e state_q, state_d;
  logic [CntBits-1:0] cnt_q;     // points stored
  logic [CntBits-1:0] dep_q;     // hull stack depth
  logic [CntBits-1:0] k_q;       // outer loop index
  logic [CntBits-1:0] m_q;       // inner loop index
  logic [IdxBits-1:0] t_q;       // element being inserted
  logic [2:0]         ph_q;      // phase within a compare
  coord_t px_q, py_q;
  res_t   turn_q;
  res_t   da_q;
  logic [IdxBits-1:0] piv_q;
  logic [CntBits-1:0] q_q;
  logic [CntBits-1:0] a_q, b_q;

  // output register
  logic o_valid_q, o_kind_q, o_last_q;
  logic [PosBits-1:0] o_pos_q;
  coord_t o_x_q, o_y_q;

  // shared unit
  chgs_pkg::op_e op;
  diff_t a0, b0, a1, b1;
  res_t  res;

  chgs_cross #(.CoordBits(CoordBits)) u_cross (
    .clk_i (clk_i), .op_i (op), .a0_i (a0), .b0_i (b0), .a1_i (a1), .b1_i (b1),
    .res_o (res)
  );

  function automatic diff_t sub(coord_t x, coord_t y);
    sub = diff_t'(x) - diff_t'(y);
  endfunction

  logic in_acc, out_free, o_set;
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !o_valid_q || out_o.ready;
  assign in_i.ready = (state_q == chgs_pkg::ST_LOAD);
  // load a new result beat into the output register
  assign o_set = out_free && ((state_q == chgs_pkg::ST_LIST && k_q < cnt_q) ||
                              state_q == chgs_pkg::ST_HULL_OUT);

  assign out_o.valid           = o_valid_q;
  assign out_o.item_kind       = o_kind_q;
  assign out_o.sorted_position = o_pos_q;
  assign out_o.out_x           = o_x_q;
  assign out_o.out_y           = o_y_q;
  assign out_o.last_result     = o_last_q;

  // index helpers: the counters are wide enough to hold the depth itself
  logic [IdxBits-1:0] ki, mi, mim1, ai, bi, qi, d1, d2, ni;
  assign ki   = k_q[IdxBits-1:0];
  assign mi   = m_q[IdxBits-1:0];
  assign mim1 = IdxBits'(m_q - 1'b1);
  assign ai   = a_q[IdxBits-1:0];
  assign bi   = b_q[IdxBits-1:0];
  assign qi   = q_q[IdxBits-1:0];
  assign d1   = IdxBits'(dep_q - 1'b1);
  assign d2   = IdxBits'(dep_q - 2'd2);
  assign ni   = IdxBits'(cnt_q - 1'b1);

  // operands of the shared unit, chosen by state and phase
  logic [IdxBits-1:0] ua, ub, uc;
  coord_t ox, oy;
  always_comb begin
    op = chgs_pkg::OP_TURN;
    ox = px_q;
    oy = py_q;
    ua = t_q;
    ub = ord_q[mim1];
    uc = ord_q[mim1];
    unique case (state_q)
      chgs_pkg::ST_SORT_CMP: begin
        ua = t_q;
        ub = ord_q[mim1];
        if (ph_q == 3'd2) begin
          op = chgs_pkg::OP_DIST;
          ub = t_q;
        end else if (ph_q == 3'd3) begin
          op = chgs_pkg::OP_DIST;
        end
      end
      chgs_pkg::ST_REV_FIND: begin
        ua = ord_q[mim1];
        ub = ord_q[ni];
      end
      chgs_pkg::ST_SCAN_CMP: begin
        ox = sx_q[ord_q[stk_q[d2]]];
        oy = sy_q[ord_q[stk_q[d2]]];
        ua = ord_q[stk_q[d1]];
        ub = ord_q[ki];
      end
      default: ;
    endcase
    uc = ub;
    if (op == chgs_pkg::OP_DIST) begin
      a0 = sub(sx_q[ub], ox);
      b0 = a0;
      a1 = sub(sy_q[ub], oy);
      b1 = a1;
    end else begin
      a0 = sub(sx_q[ua], ox);
      b0 = sub(sy_q[uc], oy);
      a1 = sub(sy_q[ua], oy);
      b1 = sub(sx_q[uc], ox);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      chgs_pkg::ST_LOAD:
        if (in_acc && in_i.final_point) state_d = chgs_pkg::ST_PIV;
      chgs_pkg::ST_PIV:
        if (k_q >= cnt_q) state_d = chgs_pkg::ST_SORT_INIT;
      chgs_pkg::ST_SORT_INIT: state_d = chgs_pkg::ST_SORT_RD;
      chgs_pkg::ST_SORT_RD:
        if (k_q >= cnt_q) state_d = chgs_pkg::ST_REV_FIND;
        else state_d = chgs_pkg::ST_SORT_CMP;
      chgs_pkg::ST_SORT_CMP:
        if (m_q == '0) state_d = chgs_pkg::ST_SORT_PUT;
        else if (ph_q == 3'd3 && turn_q != '0) begin
          if (!turn_q[ResBits-1]) state_d = chgs_pkg::ST_SORT_PUT;
        end else if (ph_q == 3'd4 && !(res > da_q)) state_d = chgs_pkg::ST_SORT_PUT;
      chgs_pkg::ST_SORT_PUT: state_d = chgs_pkg::ST_SORT_RD;
      chgs_pkg::ST_REV_FIND:
        if (m_q == '0 || (ph_q == 3'd1 && res != '0)) state_d = chgs_pkg::ST_REV_SWAP;
      chgs_pkg::ST_REV_SWAP:
        if (!(a_q < b_q)) state_d = chgs_pkg::ST_SCAN_INIT;
      chgs_pkg::ST_SCAN_INIT: state_d = chgs_pkg::ST_SCAN_CMP;
      chgs_pkg::ST_SCAN_CMP:
        if (k_q >= cnt_q) state_d = chgs_pkg::ST_LIST;
      chgs_pkg::ST_LIST:
        if (out_free && k_q >= cnt_q) state_d = chgs_pkg::ST_HULL_INIT;
      chgs_pkg::ST_HULL_INIT:
        if (k_q == '0) state_d = chgs_pkg::ST_DONE;
        else state_d = chgs_pkg::ST_HULL_DUP;
      chgs_pkg::ST_HULL_DUP:
        if (q_q <= CntBits'(stk_q[IdxBits'(k_q - 1'b1)]) ||
            (sx_q[ord_q[qi]] == sx_q[piv_q] && sy_q[ord_q[qi]] == sy_q[piv_q]))
          state_d = chgs_pkg::ST_HULL_OUT;
      chgs_pkg::ST_HULL_OUT:
        if (out_free) state_d = chgs_pkg::ST_HULL_INIT;
      chgs_pkg::ST_DONE: state_d = chgs_pkg::ST_LOAD;
      default: state_d = chgs_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= chgs_pkg::ST_LOAD;
    else state_q <= state_d;
  end

  // datapath and control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      dep_q     <= '0;
      k_q       <= '0;
      m_q       <= '0;
      ph_q      <= '0;
      o_valid_q <= 1'b0;
    end else begin
      if (o_set) o_valid_q <= 1'b1;
      else if (out_o.ready) o_valid_q <= 1'b0;
      unique case (state_q)
        chgs_pkg::ST_LOAD: begin
          k_q <= CntBits'(1);
          if (in_acc && cnt_q < CntBits'(MaxPoints)) begin
            cnt_q <= cnt_q + 1'b1;
            ord_q[cnt_q[IdxBits-1:0]] <= cnt_q[IdxBits-1:0];
          end
          piv_q <= '0;
        end
        chgs_pkg::ST_PIV: begin
          // hold the least (y, x) in piv_q
          if (k_q < cnt_q) begin
            if (sy_q[ki] < sy_q[piv_q] || (sy_q[ki] == sy_q[piv_q] && sx_q[ki] < sx_q[piv_q]))
              piv_q <= ki;
            k_q <= k_q + 1'b1;
          end else begin
            px_q <= sx_q[piv_q];
            py_q <= sy_q[piv_q];
            k_q  <= '0;
          end
        end
        chgs_pkg::ST_SORT_INIT: k_q <= CntBits'(1);
        chgs_pkg::ST_SORT_RD: begin
          t_q  <= ki;
          ph_q <= '0;
          if (k_q >= cnt_q) m_q <= cnt_q;
          else m_q <= k_q;
        end
        chgs_pkg::ST_SORT_CMP: begin
          // turn issued in phase 0, distances in 2 and 3, decisions in 3 and 4
          if (ph_q == 3'd1) turn_q <= res;
          if (ph_q == 3'd3) begin
            da_q <= res;
            if (turn_q[ResBits-1]) begin
              ord_q[mi] <= ord_q[mim1];
              m_q  <= m_q - 1'b1;
              ph_q <= '0;
            end else ph_q <= ph_q + 1'b1;
          end else if (ph_q == 3'd4) begin
            if (res > da_q) begin
              ord_q[mi] <= ord_q[mim1];
              m_q <= m_q - 1'b1;
            end
            ph_q <= '0;
          end else ph_q <= ph_q + 1'b1;
        end
        chgs_pkg::ST_SORT_PUT: begin
          ord_q[mi] <= t_q;
          k_q <= k_q + 1'b1;
        end
        chgs_pkg::ST_REV_FIND: begin
          // m walks down while collinear with pivot and last point
          if (ph_q == 3'd1) begin
            ph_q <= '0;
            if (res == '0) m_q <= m_q - 1'b1;
          end else ph_q <= ph_q + 1'b1;
          a_q <= m_q;
          b_q <= cnt_q - 1'b1;
        end
        chgs_pkg::ST_REV_SWAP: begin
          if (a_q < b_q) begin
            ord_q[ai] <= ord_q[bi];
            ord_q[bi] <= ord_q[ai];
            a_q <= a_q + 1'b1;
            b_q <= b_q - 1'b1;
          end
        end
        chgs_pkg::ST_SCAN_INIT: begin
          dep_q <= '0;
          k_q   <= '0;
          ph_q  <= '0;
        end
        chgs_pkg::ST_SCAN_CMP: begin
          if (k_q < cnt_q) begin
            if (dep_q < CntBits'(2)) begin
              stk_q[dep_q[IdxBits-1:0]] <= ki;
              dep_q <= dep_q + 1'b1;
              k_q   <= k_q + 1'b1;
              ph_q  <= '0;
            end else if (ph_q == 3'd0) begin
              ph_q <= 3'd1;
            end else begin
              ph_q <= '0;
              if (!res[ResBits-1] && res != '0) dep_q <= dep_q - 1'b1;
              else begin
                stk_q[dep_q[IdxBits-1:0]] <= ki;
                dep_q <= dep_q + 1'b1;
                k_q   <= k_q + 1'b1;
              end
            end
          end else k_q <= '0;
        end
        chgs_pkg::ST_LIST: begin
          if (out_free) begin
            if (k_q < cnt_q) begin
              o_kind_q  <= 1'b0;
              o_last_q  <= 1'b0;
              o_pos_q   <= PosBits'(k_q);
              o_x_q     <= sx_q[ord_q[ki]];
              o_y_q     <= sy_q[ord_q[ki]];
              k_q       <= k_q + 1'b1;
            end else k_q <= dep_q;
          end
        end
        chgs_pkg::ST_HULL_INIT: begin
          q_q   <= cnt_q - 1'b1;
          piv_q <= ord_q[stk_q[IdxBits'(k_q - 1'b1)]];
        end
        chgs_pkg::ST_HULL_DUP: begin
          if (!(q_q <= CntBits'(stk_q[IdxBits'(k_q - 1'b1)]) ||
                (sx_q[ord_q[qi]] == sx_q[piv_q] && sy_q[ord_q[qi]] == sy_q[piv_q])))
            q_q <= q_q - 1'b1;
        end
        chgs_pkg::ST_HULL_OUT: begin
          if (out_free) begin
            o_kind_q  <= 1'b1;
            o_last_q  <= (k_q == CntBits'(1));
            o_pos_q   <= PosBits'(q_q);
            o_x_q     <= sx_q[piv_q];
            o_y_q     <= sy_q[piv_q];
            k_q       <= k_q - 1'b1;
          end
        end
        chgs_pkg::ST_DONE: cnt_q <= '0;
        default: ;
      endcase
    end
  end

  // point store write
  always_ff @(posedge clk_i) begin
    if (in_acc && cnt_q < CntBits'(MaxPoints)) begin
      sx_q[cnt_q[IdxBits-1:0]] <= in_i.point_x;
      sy_q[cnt_q[IdxBits-1:0]] <= in_i.point_y;
    end
  end

`include "assert_macros.svh"
  `ASSERT_ALWAYS(a_cnt_range, clk_i, rst_ni, cnt_q <= CntBits'(MaxPoints))
  `ASSERT_ALWAYS(a_dep_range, clk_i, rst_ni, dep_q <= CntBits'(MaxPoints))
  `ASSERT_ALWAYS(a_no_ready_busy, clk_i, rst_ni, !in_i.ready || state_q == chgs_pkg::ST_LOAD)
  `ASSERT_NEXT(a_final_busy, clk_i, rst_ni, in_acc && in_i.final_point, !in_i.ready)
endmodule

[sim/convex_hull_graham_scan_checker.sv]
// Checker for the convex hull block: predicts the listing and hull beats and compares them
module convex_hull_graham_scan_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  chgs_point_if  pt,
  chgs_result_if res,
  output int     fail_count_o,
  output int     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                                  kind;
    logic [chgs_pkg::PosBits-1:0]          pos;
    logic signed [chgs_pkg::CoordBits-1:0] x;
    logic signed [chgs_pkg::CoordBits-1:0] y;
    logic                                  last;
  } hull_beat_t;

  hull_beat_t expected_beats[$];
  longint     pts_x[chgs_pkg::MaxPoints];
  longint     pts_y[chgs_pkg::MaxPoints];
  int         sorted_idx[chgs_pkg::MaxPoints];
  int         hull_pos[chgs_pkg::MaxPoints];
  int         n_pts;
  int         n_hull;
  int         fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_beats.size();

  function automatic int orient(longint ax, longint ay, longint bx, longint by,
                                longint cx, longint cy);
    longint v;
    v = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    return (v < 0) ? -1 : ((v > 0) ? 1 : 0);
  endfunction

  function automatic longint dist_sq(longint px, longint py, int i);
    longint dx, dy;
    dx = pts_x[i] - px;
    dy = pts_y[i] - py;
    return dx * dx + dy * dy;
  endfunction

  // clockwise order around the pivot, nearest first within one direction
  function automatic bit goes_first(longint px, longint py, int a, int b);
    int o;
    o = orient(px, py, pts_x[a], pts_y[a], pts_x[b], pts_y[b]);
    if (o == 0) return dist_sq(px, py, a) < dist_sq(px, py, b);
    return o < 0;
  endfunction

  function automatic int turn_at(int a, int b, int c);
    return orient(pts_x[sorted_idx[a]], pts_y[sorted_idx[a]],
                  pts_x[sorted_idx[b]], pts_y[sorted_idx[b]],
                  pts_x[sorted_idx[c]], pts_y[sorted_idx[c]]);
  endfunction

  // append one beat to the tail of the expected queue
  function automatic void add_beat(hull_beat_t hb);
    expected_beats.insert(expected_beats.size(), hb);
  endfunction

  task automatic predict_hull();
    int piv, m, t, lo, a, b, p, q, lst;
    longint px, py;
    hull_beat_t hb;
    piv = 0;
    for (int k = 1; k < n_pts; k++) begin
      if (pts_y[k] < pts_y[piv] || (pts_y[k] == pts_y[piv] && pts_x[k] < pts_x[piv]))
        piv = k;
    end
    px = pts_x[piv];
    py = pts_y[piv];
    for (int k = 0; k < n_pts; k++) sorted_idx[k] = k;
    for (int k = 1; k < n_pts; k++) begin
      t = sorted_idx[k];
      m = k;
      while (m > 0 && goes_first(px, py, t, sorted_idx[m-1])) begin
        sorted_idx[m] = sorted_idx[m-1];
        m--;
      end
      sorted_idx[m] = t;
    end
    // reverse the tail that lies on one ray from the pivot
    lst = sorted_idx[n_pts-1];
    lo = n_pts - 1;
    while (lo >= 0 && orient(px, py, pts_x[sorted_idx[lo]], pts_y[sorted_idx[lo]],
                             pts_x[lst], pts_y[lst]) == 0)
      lo--;
    a = lo + 1;
    b = n_pts - 1;
    while (a < b) begin
      t = sorted_idx[a];
      sorted_idx[a] = sorted_idx[b];
      sorted_idx[b] = t;
      a++;
      b--;
    end
    // pop on a left turn, so collinear hull points stay
    n_hull = 0;
    for (int k = 0; k < n_pts; k++) begin
      while (n_hull > 1 && turn_at(hull_pos[n_hull-2], hull_pos[n_hull-1], k) > 0)
        n_hull--;
      hull_pos[n_hull++] = k;
    end
    for (int k = 0; k < n_pts; k++) begin
      hb.kind = 1'b0;
      hb.pos  = k[chgs_pkg::PosBits-1:0];
      hb.x    = pts_x[sorted_idx[k]][chgs_pkg::CoordBits-1:0];
      hb.y    = pts_y[sorted_idx[k]][chgs_pkg::CoordBits-1:0];
      hb.last = 1'b0;
      add_beat(hb);
    end
    for (int k = n_hull; k > 0; k--) begin
      p = hull_pos[k-1];
      q = n_pts - 1;
      // a duplicate reports its highest sorted position
      while (q > p && !(pts_x[sorted_idx[q]] == pts_x[sorted_idx[p]] &&
                        pts_y[sorted_idx[q]] == pts_y[sorted_idx[p]]))
        q--;
      hb.kind = 1'b1;
      hb.pos  = q[chgs_pkg::PosBits-1:0];
      hb.x    = pts_x[sorted_idx[p]][chgs_pkg::CoordBits-1:0];
      hb.y    = pts_y[sorted_idx[p]][chgs_pkg::CoordBits-1:0];
      hb.last = (k == 1);
      add_beat(hb);
    end
    n_pts = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hull_beat_t hb;
    if (!rst_ni) begin
      n_pts = 0;
      fails = 0;
      expected_beats.delete();
    end else begin
      if (pt.valid && pt.ready) begin
        if (n_pts < chgs_pkg::MaxPoints) begin
          pts_x[n_pts] = longint'(pt.point_x);
          pts_y[n_pts] = longint'(pt.point_y);
          n_pts++;
        end
        if (pt.final_point) predict_hull();
      end
      if (res.valid && res.ready) begin
        if (expected_beats.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result beat kind=%0d pos=%0d",
                                    res.item_kind, res.sorted_position);
        end else begin
          hb = expected_beats.pop_front();
          if (res.item_kind !== hb.kind || res.sorted_position !== hb.pos ||
              res.out_x !== hb.x || res.out_y !== hb.y || res.last_result !== hb.last) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp kind=%0d pos=%0d x=%0d y=%0d last=%0d, ",
                       hb.kind, hb.pos, hb.x, hb.y, hb.last,
                       "got kind=%0d pos=%0d x=%0d y=%0d last=%0d",
                       res.item_kind, res.sorted_position, res.out_x, res.out_y,
                       res.last_result);
          end
        end
      end
    end
  end
endmodule

[sim/convex_hull_graham_scan_tb.sv]
// Testbench top: drives point sets into the convex hull block and gives the verdict
module convex_hull_graham_scan_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1500000;
  localparam int RandomItems = 200;

  typedef logic signed [chgs_pkg::CoordBits-1:0] coord_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   calm = 1'b0;       // no idling on either side while set
  logic point_taken;
  int   cycles = 0;
  int   fail_count;
  int   pending;
  int   items_sent = 0;

  chgs_point_if  pt_if ();
  chgs_result_if res_if ();

  convex_hull_graham_scan i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pt_if),
    .out_o (res_if)
  );

  convex_hull_graham_scan_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pt          (pt_if),
    .res         (res_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // a beat moved at this rising edge; read back at the next falling edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_taken <= 1'b0;
    end else begin
      point_taken <= pt_if.valid && pt_if.ready;
    end
  end

  // stall the result sink at random, except in the calm stretch
  always @(negedge clk_i) begin
    res_if.ready = calm || ($urandom_range(99) >= 38);
  end

  // watchdog: abandon a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // hold valid low for a random gap, then present one point until it is taken
  task automatic send_point(coord_t x, coord_t y, bit fin);
    while (!calm && $urandom_range(99) < 38) begin
      pt_if.valid = 1'b0;
      @(negedge clk_i);
    end
    pt_if.valid       = 1'b1;
    pt_if.point_x     = x;
    pt_if.point_y     = y;
    pt_if.final_point = fin;
    do @(negedge clk_i); while (!point_taken);
    items_sent++;
  endtask

  function automatic coord_t any_coord(int mode);
    case (mode)
      0:       return coord_t'($urandom);
      1:       return coord_t'($signed($urandom_range(6)) - 3);
      default: return coord_t'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  // one set of n points; shape picks full range, a tight grid, a line or +-1000
  task automatic send_set(int n, int shape);
    coord_t bx, by, dx, dy;
    bx = any_coord(2);
    by = any_coord(2);
    dx = coord_t'($signed($urandom_range(6)) - 3);
    dy = coord_t'($signed($urandom_range(6)) - 3);
    for (int k = 0; k < n; k++) begin
      case (shape)
        0: send_point(any_coord(0), any_coord(0), k == n - 1);
        1: send_point(any_coord(1), any_coord(1), k == n - 1);
        2: send_point(bx + dx * coord_t'($urandom_range(8)),
                      by + dy * coord_t'($urandom_range(8)), k == n - 1);
        default: send_point(any_coord(2), any_coord(2), k == n - 1);
      endcase
    end
  endtask

  initial begin
    int n, sets;
    pt_if.valid       = 1'b0;
    pt_if.point_x     = '0;
    pt_if.point_y     = '0;
    pt_if.final_point = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // single point at the most negative corner
    send_point(coord_t'(-1048576), coord_t'(-1048576), 1'b1);
    // extreme corners
    send_point(coord_t'(1048575), coord_t'(1048575), 1'b0);
    send_point(coord_t'(-1048576), coord_t'(1048575), 1'b0);
    send_point(coord_t'(1048575), coord_t'(-1048576), 1'b0);
    send_point(coord_t'(-1048576), coord_t'(-1048576), 1'b1);
    // every point on one line: whole order reversed
    send_point(coord_t'(3), coord_t'(3), 1'b0);
    send_point(coord_t'(0), coord_t'(0), 1'b0);
    send_point(coord_t'(1), coord_t'(1), 1'b0);
    send_point(coord_t'(2), coord_t'(2), 1'b1);
    // square with a point on its left edge and one inside
    send_point(coord_t'(0), coord_t'(0), 1'b0);
    send_point(coord_t'(2), coord_t'(0), 1'b0);
    send_point(coord_t'(2), coord_t'(2), 1'b0);
    send_point(coord_t'(0), coord_t'(2), 1'b0);
    send_point(coord_t'(0), coord_t'(1), 1'b0);
    send_point(coord_t'(1), coord_t'(1), 1'b1);
    // repeated points
    send_point(coord_t'(5), coord_t'(-7), 1'b0);
    send_point(coord_t'(5), coord_t'(-7), 1'b0);
    send_point(coord_t'(-4), coord_t'(9), 1'b0);
    send_point(coord_t'(5), coord_t'(-7), 1'b1);

    // hold off until the block has drained completely
    pt_if.valid = 1'b0;
    wait (pending == 0);
    @(negedge clk_i);

    // store overflow: two points beyond capacity, last one carries the flag
    send_set(chgs_pkg::MaxPoints + 2, 3);

    sets = 0;
    while (items_sent < RandomItems) begin
      calm = (sets >= 12 && sets < 17);
      n = ($urandom_range(11) == 0) ? chgs_pkg::MaxPoints : $urandom_range(8, 1);
      send_set(n, $urandom_range(3));
      sets++;
    end
    calm = 1'b0;
    pt_if.valid = 1'b0;

    wait (pending == 0);
    repeat (300) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+sv
sv/chgs_pkg.sv
sv/chgs_point_if.sv
sv/chgs_cross.sv
sv/convex_hull_graham_scan.sv
sim/convex_hull_graham_scan_checker.sv
sim/convex_hull_graham_scan_tb.sv
